@@ hw/rtl/scbs_pkg.sv @@
// Shared types, constants and sine table builder for the stereo buss saturator.
`default_nettype none

package scbs_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int TRIG_DEPTH_DEF  = 1024;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUB_TRIM       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLEW_THRESHOLD = 2'd1;

   localparam logic [15:0] SUB_TRIM_RESET = 16'd18455;
   localparam logic [16:0] SLEW_THR_RESET = 17'd47055;

   localparam logic signed [33:0] TURN_PER_RAD = 34'sd683565276;
   localparam logic [31:0]        COS_OFFSET   = 32'h4000_0000;
   localparam logic [33:0]        WONE_Q28     = 34'd268435456;
   localparam logic signed [35:0] CLIP_POS     = 36'sd751619277;
   localparam logic signed [35:0] CLIP_NEG     = -36'sd751619277;
   localparam logic [29:0]        THREE_Q28    = 30'd805306368;
   localparam logic signed [32:0] U_CLAMP_POS  = 33'sd67108864;
   localparam logic signed [32:0] U_CLAMP_NEG  = -33'sd67108864;
   localparam logic signed [36:0] ONE_POS      = 37'sd268435456;
   localparam logic signed [36:0] ONE_NEG      = -37'sd268435456;
   localparam logic [5:0]         DIV_LAST     = 6'd32;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned QONE        = 64'd1073741824;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_MTRIM, OP_GETU, OP_SSCALE, OP_TPHASE, OP_TADDR, OP_TRDA,
      OP_TRDB, OP_TINT, OP_TSUM, OP_SMUL1, OP_SV, OP_SMUL2, OP_SZ, OP_SUBT, OP_AMUL,
      OP_AWR, OP_CLIP, OP_DIV, OP_DIVEND, OP_COSARG, OP_SLMUL, OP_SLEW, OP_FINAL
   } dp_op_type;

   typedef enum logic [4:0] {
      CS_IDLE, CS_LOAD, CS_MTRIM, CS_GETU, CS_SSCALE, CS_TPHASE, CS_TADDR, CS_TRDA,
      CS_TRDB, CS_TINT, CS_TSUM, CS_SMUL1, CS_SV, CS_SMUL2, CS_SZ, CS_SUBT, CS_AMUL,
      CS_AWR, CS_CLIP, CS_DIV, CS_DIVEND, CS_COSARG, CS_SLMUL, CS_SLEW, CS_FINAL,
      CS_PUBLISH
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic       chan;
      logic [1:0] stage;
      logic       cos;
      logic       capture;
      logic       publish;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

   // Q1.30 sine of a phase in 2^-32 turns, odd Taylor series mirrored from the first quadrant
   function automatic logic signed [31:0] sine_entry(input longint unsigned p);
      longint unsigned q;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      q = (p >> 30) & 64'd3;
      r = p & 64'h3FFF_FFFF;
      if (q[0]) r = 64'h4000_0000 - r;
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = QONE;
      t  = QONE - (((x2 * t) >> 30) / 64'd110);
      t  = QONE - (((x2 * t) >> 30) / 64'd72);
      t  = QONE - (((x2 * t) >> 30) / 64'd42);
      t  = QONE - (((x2 * t) >> 30) / 64'd20);
      t  = QONE - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      return q[1] ? -32'(s) : 32'(s);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scbs_trig_rom.sv @@
// Sine lookup ROM, one full period, registered read.
`default_nettype none

module scbs_trig_rom
   import scbs_pkg::*;
#(
   parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic [$clog2(TRIG_TABLE_DEPTH)-1:0]   rd_addr,
   output logic signed [31:0]                         rd_data
);

   logic signed [31:0] tab [TRIG_TABLE_DEPTH];
   logic signed [31:0] rd_data_ff;

   for (genvar k = 0; k < TRIG_TABLE_DEPTH; k++) begin : g_tab
      localparam longint unsigned Phase = (64'(k) << 32) / TRIG_TABLE_DEPTH;
      assign tab[k] = sine_entry(Phase);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= tab[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/scbs_datapath.sv @@
// Datapath: shared multiplier, sine lookup, serial divider, stage state and result registers.
`default_nettype none

module scbs_datapath
   import scbs_pkg::*;
#(
   parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
   parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire dp_cmd_type                       cmd,
   output dp_status_type                         status,
   input  wire logic signed [SAMPLE_BITS-1:0]    sample_left,
   input  wire logic signed [SAMPLE_BITS-1:0]    sample_right,
   input  wire logic [16:0]                      fader_gain,
   input  wire logic                             csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]        csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]         csr_wdata,
   output logic signed [SAMPLE_BITS-1:0]         out_left,
   output logic signed [SAMPLE_BITS-1:0]         out_right
);

   localparam int SHIFT = 32 - SAMPLE_BITS;
   localparam int AW    = $clog2(TRIG_TABLE_DEPTH);
   localparam int POS_W = 32 + AW;
   localparam logic signed [36:0] ROUND_ADD = 37'((64'sd1 <<< SHIFT) >>> 1);
   localparam logic signed [36:0] RES_MAX   = 37'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [36:0] RES_MIN   = 37'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
   localparam logic [AW-1:0]      LAST_IDX  = AW'(TRIG_TABLE_DEPTH - 1);

   // configuration and per-channel state
   logic [15:0]                   trim_ff;
   logic [16:0]                   thr_ff;
   logic signed [31:0]            sub_ff  [2][3];
   logic signed [23:0]            last_ff [2];

   // working registers
   logic signed [SAMPLE_BITS-1:0] smp_ff [2];
   logic [16:0]                   gain_ff;
   logic signed [35:0]            x_ff;
   logic signed [32:0]            u_ff;
   logic [30:0]                   scale_ff;
   logic signed [32:0]            arg_ff;
   logic [AW-1:0]                 idx_ff;
   logic [AW-1:0]                 idx_nx_ff;
   logic [15:0]                   frac_ff;
   logic signed [31:0]            tab_a_ff;
   logic signed [32:0]            trig_ff;
   logic signed [31:0]            v_ff;
   logic signed [67:0]            prod_ff;
   logic [29:0]                   dvs_ff;
   logic [29:0]                   rem_ff;
   logic [32:0]                   num_ff;
   logic [32:0]                   quo_ff;
   logic                          neg_ff;
   logic [5:0]                    div_cnt_ff;
   logic signed [SAMPLE_BITS-1:0] res_ff [2];
   logic signed [SAMPLE_BITS-1:0] out_left_ff;
   logic signed [SAMPLE_BITS-1:0] out_right_ff;

   // combinational helpers
   logic signed [31:0]            z_sel;
   logic signed [23:0]            last_sel;
   logic signed [31:0]            x_load;
   logic [32:0]                   u_abs;
   logic [30:0]                   scale_in;
   logic signed [32:0]            arg_in;
   logic [31:0]                   phase;
   logic [POS_W-1:0]              pos;
   logic [AW-1:0]                 idx_in;
   logic [AW-1:0]                 rom_addr;
   logic signed [31:0]            rom_q;
   logic signed [32:0]            tab_d;
   logic signed [34:0]            v_sum;
   logic signed [31:0]            v_in;
   logic signed [35:0]            z_wide;
   logic signed [31:0]            z_in;
   logic signed [32:0]            u_sat;
   logic signed [35:0]            x_clip;
   logic [29:0]                   mag;
   logic [30:0]                   r2;
   logic                          r2_ge;
   logic [29:0]                   rem_in;
   logic signed [35:0]            quo_s;
   logic signed [36:0]            sinew;
   logic signed [36:0]            last_x;
   logic signed [36:0]            diff;
   logic signed [36:0]            temp;
   logic signed [36:0]            temp_sat;
   logic signed [36:0]            rnd;
   logic signed [36:0]            rnd_sat;
   logic signed [33:0]            mul_a;
   logic signed [33:0]            mul_b;

   scbs_trig_rom #(
      .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
   ) u_rom (
      .clock  (clock),
      .rd_addr(rom_addr),
      .rd_data(rom_q)
   );

   assign rom_addr = (cmd.op == OP_TRDB) ? idx_nx_ff : idx_ff;

   always_comb begin
      z_sel    = sub_ff[cmd.chan][cmd.stage];
      last_sel = last_ff[cmd.chan];
      x_load   = 32'(smp_ff[cmd.chan]) <<< SHIFT;

      u_abs    = u_ff[32] ? 33'(-u_ff) : 33'(u_ff);
      scale_in = 31'((34'(u_abs) + WONE_Q28) >> 1);
      arg_in   = 33'(34'(z_sel) - 34'(u_ff));

      phase  = prod_ff[59:28] + (cmd.cos ? COS_OFFSET : 32'd0);
      pos    = POS_W'(phase) * POS_W'(TRIG_TABLE_DEPTH);
      idx_in = pos[POS_W-1:32];
      tab_d  = 33'(rom_q) - 33'(tab_a_ff);

      v_sum = 35'(z_sel) + 35'(prod_ff >>> 30);
      if (v_sum > 35'sd2147483647) v_in = 32'sh7FFF_FFFF;
      else if (v_sum < -35'sd2147483648) v_in = 32'sh8000_0000;
      else v_in = 32'(v_sum);

      z_wide = 36'(prod_ff >>> 28);
      if (z_wide > 36'sd2147483647) z_in = 32'sh7FFF_FFFF;
      else if (z_wide < -36'sd2147483648) z_in = 32'sh8000_0000;
      else z_in = 32'(z_wide);

      if (u_ff > U_CLAMP_POS) u_sat = U_CLAMP_POS;
      else if (u_ff < U_CLAMP_NEG) u_sat = U_CLAMP_NEG;
      else u_sat = u_ff;

      if (x_ff > CLIP_POS) x_clip = CLIP_POS;
      else if (x_ff < CLIP_NEG) x_clip = CLIP_NEG;
      else x_clip = x_ff;
      mag = x_clip[35] ? 30'(-x_clip) : 30'(x_clip);

      // restoring divider: one quotient bit per beat
      r2     = {rem_ff, num_ff[32]};
      r2_ge  = r2 >= {1'b0, dvs_ff};
      rem_in = r2_ge ? 30'(r2 - {1'b0, dvs_ff}) : r2[29:0];
      quo_s  = $signed({3'b000, quo_ff});

      sinew  = 37'(prod_ff >>> 18);
      last_x = 37'(last_sel) <<< 6;
      diff   = 37'(x_ff) - last_x;
      temp   = 37'(x_ff);
      if (diff > sinew) temp = last_x + sinew;
      if (-diff > sinew) temp = last_x - sinew;
      if (temp > ONE_POS) temp_sat = ONE_POS;
      else if (temp < ONE_NEG) temp_sat = ONE_NEG;
      else temp_sat = temp;

      rnd = (37'(x_ff) + ROUND_ADD) >>> SHIFT;
      if (rnd > RES_MAX) rnd_sat = RES_MAX;
      else if (rnd < RES_MIN) rnd_sat = RES_MIN;
      else rnd_sat = rnd;
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (cmd.op)
         OP_MTRIM: begin
            mul_a = 34'(x_ff);
            mul_b = $signed({18'd0, trim_ff});
         end
         OP_TPHASE: begin
            mul_a = 34'(arg_ff);
            mul_b = TURN_PER_RAD;
         end
         OP_TINT: begin
            mul_a = 34'(tab_d);
            mul_b = $signed({18'd0, frac_ff});
         end
         OP_SMUL1: begin
            mul_a = 34'(trig_ff);
            mul_b = $signed({3'd0, scale_ff});
         end
         OP_SMUL2: begin
            mul_a = 34'(v_ff);
            mul_b = $signed({3'd0, scale_ff});
         end
         OP_AMUL: begin
            mul_a = 34'(x_ff);
            mul_b = $signed({17'd0, gain_ff});
         end
         OP_SLMUL: begin
            mul_a = 34'(trig_ff);
            mul_b = $signed({17'd0, thr_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff <= SUB_TRIM_RESET;
         thr_ff  <= SLEW_THR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SUB_TRIM:       trim_ff <= csr_wdata[15:0];
            CSR_SLEW_THRESHOLD: thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            last_ff[c] <= '0;
            for (int s = 0; s < 3; s++) sub_ff[c][s] <= '0;
         end
      end else begin
         if (cmd.op == OP_SZ) sub_ff[cmd.chan][cmd.stage] <= z_in;
         if (cmd.op == OP_SLEW) last_ff[cmd.chan] <= 24'((temp_sat + 37'sd32) >>> 6);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.capture) begin
         smp_ff[0] <= sample_left;
         smp_ff[1] <= sample_right;
         gain_ff   <= fader_gain;
      end
      if (cmd.publish) begin
         out_left_ff  <= res_ff[0];
         out_right_ff <= res_ff[1];
      end
      unique case (cmd.op)
         OP_LOAD:   x_ff <= 36'(x_load);
         OP_GETU:   u_ff <= 33'(prod_ff >>> 24);
         OP_SSCALE: begin
            scale_ff <= scale_in;
            arg_ff   <= arg_in;
         end
         OP_TADDR: begin
            idx_ff    <= idx_in;
            idx_nx_ff <= (idx_in == LAST_IDX) ? '0 : idx_in + 1'b1;
            frac_ff   <= pos[31:16];
         end
         OP_TRDB:   tab_a_ff <= rom_q;
         OP_TSUM:   trig_ff <= 33'(tab_a_ff) + 33'(prod_ff >>> 16);
         OP_SV:     v_ff <= v_in;
         OP_SZ:     u_ff <= 33'(v_ff);
         OP_SUBT:   x_ff <= x_ff - (36'(u_sat) <<< 4);
         OP_AWR: begin
            // gain at or above unity bypasses
            if (!gain_ff[16]) x_ff <= 36'(prod_ff >>> 16);
         end
         OP_CLIP: begin
            neg_ff     <= x_clip[35];
            dvs_ff     <= THREE_Q28 - mag;
            rem_ff     <= 30'(mag >> 4);
            num_ff     <= {mag[3:0], 29'd0};
            quo_ff     <= '0;
            div_cnt_ff <= '0;
         end
         OP_DIV: begin
            rem_ff     <= rem_in;
            num_ff     <= num_ff << 1;
            quo_ff     <= {quo_ff[31:0], r2_ge};
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         OP_DIVEND: x_ff <= neg_ff ? -quo_s : quo_s;
         OP_COSARG: arg_ff <= 33'(last_sel) <<< 6;
         OP_SLEW:   x_ff <= 36'(temp);
         OP_FINAL:  res_ff[cmd.chan] <= SAMPLE_BITS'(rnd_sat);
         default: ;
      endcase
   end

   assign status.div_last = (div_cnt_ff == DIV_LAST);
   assign out_left        = out_left_ff;
   assign out_right       = out_right_ff;

endmodule

`default_nettype wire

@@ hw/rtl/scbs_ctrl.sv @@
// Controller: sequences the datapath through both channels and runs the handshakes.
`default_nettype none

module scbs_ctrl
   import scbs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   logic           chan_ff, chan_in;
   logic [1:0]     stage_ff, stage_in;
   logic [1:0]     att_ff, att_in;
   logic           cos_ff, cos_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           publish;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign publish   = (state_ff == CS_PUBLISH) && slot_free;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      stage_in = stage_ff;
      att_in   = att_ff;
      cos_in   = cos_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = CS_LOAD;
               chan_in  = 1'b0;
            end
         end
         CS_LOAD:  state_in = CS_MTRIM;
         CS_MTRIM: state_in = CS_GETU;
         CS_GETU: begin
            state_in = CS_SSCALE;
            stage_in = 2'd0;
         end
         CS_SSCALE: begin
            state_in = CS_TPHASE;
            cos_in   = 1'b0;
         end
         CS_TPHASE: state_in = CS_TADDR;
         CS_TADDR:  state_in = CS_TRDA;
         CS_TRDA:   state_in = CS_TRDB;
         CS_TRDB:   state_in = CS_TINT;
         CS_TINT:   state_in = CS_TSUM;
         CS_TSUM:   state_in = cos_ff ? CS_SLMUL : CS_SMUL1;
         CS_SMUL1:  state_in = CS_SV;
         CS_SV:     state_in = CS_SMUL2;
         CS_SMUL2:  state_in = CS_SZ;
         CS_SZ: begin
            if (stage_ff == 2'd2) begin
               state_in = CS_SUBT;
            end else begin
               state_in = CS_SSCALE;
               stage_in = stage_ff + 1'b1;
            end
         end
         CS_SUBT: begin
            state_in = CS_AMUL;
            att_in   = 2'd0;
         end
         CS_AMUL: state_in = CS_AWR;
         CS_AWR: begin
            att_in = att_ff + 1'b1;
            priority if (att_ff == 2'd0) state_in = CS_CLIP;
            else if (att_ff == 2'd1) state_in = CS_COSARG;
            else state_in = CS_FINAL;
         end
         CS_CLIP: state_in = CS_DIV;
         CS_DIV: begin
            if (status.div_last) state_in = CS_DIVEND;
         end
         CS_DIVEND: state_in = CS_AMUL;
         CS_COSARG: begin
            state_in = CS_TPHASE;
            cos_in   = 1'b1;
         end
         CS_SLMUL: state_in = CS_SLEW;
         CS_SLEW:  state_in = CS_AMUL;
         CS_FINAL: begin
            if (!chan_ff) begin
               state_in = CS_LOAD;
               chan_in  = 1'b1;
            end else begin
               state_in = CS_PUBLISH;
            end
         end
         CS_PUBLISH: begin
            if (slot_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase

      priority if (publish) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_comb begin
      cmd.chan    = chan_ff;
      cmd.stage   = stage_ff;
      cmd.cos     = cos_ff;
      cmd.capture = (state_ff == CS_IDLE) && req_valid;
      cmd.publish = publish;
      unique case (state_ff)
         CS_LOAD:   cmd.op = OP_LOAD;
         CS_MTRIM:  cmd.op = OP_MTRIM;
         CS_GETU:   cmd.op = OP_GETU;
         CS_SSCALE: cmd.op = OP_SSCALE;
         CS_TPHASE: cmd.op = OP_TPHASE;
         CS_TADDR:  cmd.op = OP_TADDR;
         CS_TRDA:   cmd.op = OP_TRDA;
         CS_TRDB:   cmd.op = OP_TRDB;
         CS_TINT:   cmd.op = OP_TINT;
         CS_TSUM:   cmd.op = OP_TSUM;
         CS_SMUL1:  cmd.op = OP_SMUL1;
         CS_SV:     cmd.op = OP_SV;
         CS_SMUL2:  cmd.op = OP_SMUL2;
         CS_SZ:     cmd.op = OP_SZ;
         CS_SUBT:   cmd.op = OP_SUBT;
         CS_AMUL:   cmd.op = OP_AMUL;
         CS_AWR:    cmd.op = OP_AWR;
         CS_CLIP:   cmd.op = OP_CLIP;
         CS_DIV:    cmd.op = OP_DIV;
         CS_DIVEND: cmd.op = OP_DIVEND;
         CS_COSARG: cmd.op = OP_COSARG;
         CS_SLMUL:  cmd.op = OP_SLMUL;
         CS_SLEW:   cmd.op = OP_SLEW;
         CS_FINAL:  cmd.op = OP_FINAL;
         default:   cmd.op = OP_NOP;
      endcase
      req_stall = (state_ff != CS_IDLE);
      rsp_valid = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         chan_ff      <= 1'b0;
         stage_ff     <= 2'd0;
         att_ff       <= 2'd0;
         cos_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         stage_ff     <= stage_in;
         att_ff       <= att_in;
         cos_ff       <= cos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_rise_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == CS_PUBLISH))
      else $error("result beat raised outside publish");

   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_DIV && !status.div_last) |=> (state_ff == CS_DIV))
      else $error("divider left before last quotient bit");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff != 2'd3)
      else $error("sub stage index out of range");

   a_chan_switch: assert property (@(posedge clock) disable iff (reset)
      !$stable(chan_ff) |-> $past(state_ff == CS_FINAL || state_ff == CS_IDLE))
      else $error("channel changed mid computation");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_PUBLISH && rsp_valid_ff && rsp_stall) |=> (state_ff == CS_PUBLISH))
      else $error("publish left while output slot occupied");

endmodule

`default_nettype wire

@@ hw/rtl/stereo_console_buss_saturator.sv @@
// Top level of the stereo console buss saturator.
// Each accepted beat carries one stereo pair (signed Q3.20) and a Q1.16 gain and yields one
// processed pair. The two channels of a pair run one after the other through a single shared
// 34x34 multiplier, a sine ROM with one registered read per cycle (two reads per sine or
// cosine), and a bit-serial divider for the rational saturator; a publish state and an idle
// state follow, and the next pair is accepted only from the idle state.
// A finished pair waits in the output register, so the next pair is accepted as soon as the
// previous one has been published. Stalls on the result side hold a finished pair in the
// publish state until the output slot is free.
// Configuration writes apply from the next item and should only be made while idle.
`default_nettype none

module stereo_console_buss_saturator
   import scbs_pkg::*;
#(
   parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
   parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_left,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_right,
   input  wire logic [16:0]                   req_fader_gain,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]      rsp_out_right,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   scbs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   scbs_datapath #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .sample_left (req_sample_left),
      .sample_right(req_sample_right),
      .fader_gain  (req_fader_gain),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .out_left    (rsp_out_left),
      .out_right   (rsp_out_right)
   );

endmodule

`default_nettype wire

@@ dv/tb_stereo_console_buss_saturator.sv @@
// Testbench for the stereo buss saturator: directed table, random pairs, bit-exact predictor.
`timescale 1ns / 100ps

module tb_stereo_console_buss_saturator
   import scbs_pkg::*;
();

   localparam int  SB          = 24;
   localparam int  TAB_DEPTH   = 1024;
   localparam int  CYCLE_LIMIT = 1_500_000;
   localparam int  LONG_HOLD   = 400;
   localparam int  TAIL_WAIT   = 400;
   localparam logic [16:0] GAIN_UNITY = 17'd65536;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam longint WQ = 64'sd268435456;

   typedef struct {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
      logic [16:0]          gain;
      bit                   known;
      logic signed [SB-1:0] exp_left;
      logic signed [SB-1:0] exp_right;
   } stim_row_type;

   typedef struct {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
   } pair_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [SB-1:0] req_sample_left;
   logic signed [SB-1:0] req_sample_right;
   logic [16:0] req_fader_gain;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [SB-1:0] rsp_out_left;
   logic signed [SB-1:0] rsp_out_right;
   logic csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   stereo_console_buss_saturator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample_left(req_sample_left), .req_sample_right(req_sample_right),
      .req_fader_gain(req_fader_gain),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_left(rsp_out_left), .rsp_out_right(rsp_out_right),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   int     sine_tab[TAB_DEPTH];
   longint sub_mem[2][3];
   longint slew_mem[2];
   longint trim_reg;
   longint thr_reg;

   pair_type pending_pairs[$];
   int     mismatch_count;
   int     cycle_count;
   bit     quiet;
   bit     hold_req;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void build_sine_tab();
      longint unsigned dens[5];
      longint unsigned p, q, r, x, x2, t;
      dens = '{110, 72, 42, 20, 6};
      for (int k = 0; k < TAB_DEPTH; k++) begin
         p = (longint'(k) << 32) / TAB_DEPTH;
         q = (p >> 30) & 3;
         r = p & 64'h3FFF_FFFF;
         if (q[0]) r = 64'h4000_0000 - r;
         x  = (r * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         t  = QONE;
         for (int i = 0; i < 5; i++) t = QONE - ((x2 * t) >> 30) / dens[i];
         sine_tab[k] = q[1] ? -int'((x * t) >> 30) : int'((x * t) >> 30);
      end
   endfunction

   // Q1.30 sine of a Q.28 angle in radians, offset in 2^-32 turns
   function automatic longint trig_q30(longint arg, logic [31:0] offset);
      longint unsigned prod, pos;
      logic [31:0] phase;
      longint idx, frac, a, b;
      prod  = arg * longint'(TURN_PER_RAD);
      phase = 32'(prod >> 28) + offset;
      pos   = longint'({32'b0, phase}) * TAB_DEPTH;
      idx   = pos >> 32;
      frac  = (pos & 64'hFFFF_FFFF) >> 16;
      a = sine_tab[idx % TAB_DEPTH];
      b = sine_tab[(idx + 1) % TAB_DEPTH];
      return a + (((b - a) * frac) >>> 16);
   endfunction

   function automatic longint sub_bass_stage(int ch, int st, longint u);
      longint scale, v;
      scale = (WQ + (u < 0 ? -u : u)) >>> 1;
      v = sub_mem[ch][st] + ((trig_q30(sub_mem[ch][st] - u, 32'd0) * scale) >>> 30);
      v = clamp(v, -8 * WQ, 8 * WQ - 1);
      sub_mem[ch][st] = clamp((v * scale) >>> 28, -64'sd2147483648, 64'sd2147483647);
      return v;
   endfunction

   function automatic longint attenuate(longint x, longint g);
      return (g < GAIN_UNITY) ? ((x * g) >>> 16) : x;
   endfunction

   function automatic logic signed [SB-1:0] channel_out(int ch, logic signed [SB-1:0] smp,
                                                        longint g);
      longint x, u, mag, q, last, step, diff, temp;
      x = longint'(smp) * 256;
      u = (x * trim_reg) >>> 24;
      for (int st = 0; st < 3; st++) u = sub_bass_stage(ch, st, u);
      u = clamp(u, -WQ / 4, WQ / 4);
      x = x - u * 16;
      x = attenuate(x, g);
      x = clamp(x, -longint'(CLIP_POS), longint'(CLIP_POS));
      mag = x < 0 ? -x : x;
      q = (2 * mag * WQ) / (3 * WQ - mag);
      x = x < 0 ? -q : q;
      x = attenuate(x, g);
      last = slew_mem[ch] * 64;
      step = (thr_reg * trig_q30(last, COS_OFFSET)) >>> 18;
      diff = x - last;
      temp = x;
      if (diff > step) temp = last + step;
      if (-diff > step) temp = last - step;
      slew_mem[ch] = (clamp(temp, -WQ, WQ) + 32) >>> 6;
      x = attenuate(temp, g);
      return SB'(clamp((x + 128) >>> 8, -(64'sd1 << (SB - 1)), (64'sd1 << (SB - 1)) - 1));
   endfunction

   function automatic pair_type buss_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r,
                                          logic [16:0] g);
      pair_type p;
      p.left  = channel_out(0, l, longint'(g));
      p.right = channel_out(1, r, longint'(g));
      return p;
   endfunction

   task automatic report_mismatch(string what, logic signed [SB-1:0] got,
                                  logic signed [SB-1:0] want);
      $display("%0t %s: got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // stimulus table: expected values typed in for obvious rows only
   stim_row_type dir_rows[18] = '{
      '{24'sd0, 24'sd0, 17'd65536, 1'b1, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'sd8388607, 17'd65536, 1'b0, 24'sd0, 24'sd0},
      '{-24'sd8388608, -24'sd8388608, 17'd65536, 1'b0, 24'sd0, 24'sd0},
      '{24'sd8388607, -24'sd8388608, 17'd65536, 1'b0, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'sd8388607, 17'd131071, 1'b0, 24'sd0, 24'sd0},
      '{24'sd8388607, -24'sd8388608, 17'd0, 1'b1, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'sd8388607, 17'd0, 1'b1, 24'sd0, 24'sd0},
      '{24'sd1, -24'sd1, 17'd65535, 1'b0, 24'sd0, 24'sd0},
      '{24'sd1048576, -24'sd1048576, 17'd1, 1'b0, 24'sd0, 24'sd0},
      '{24'sd2936013, -24'sd2936013, 17'd65536, 1'b0, 24'sd0, 24'sd0},
      '{24'sd3000000, -24'sd3000000, 17'd65537, 1'b0, 24'sd0, 24'sd0},
      '{24'sd262144, 24'sd262144, 17'd32768, 1'b0, 24'sd0, 24'sd0},
      '{24'sd0, 24'sd0, 17'd65536, 1'b0, 24'sd0, 24'sd0},
      '{24'sd5592405, -24'sd5592406, 17'd43690, 1'b0, 24'sd0, 24'sd0},
      '{-24'sd1, 24'sd0, 17'd87381, 1'b0, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'sd8388607, 17'd65535, 1'b0, 24'sd0, 24'sd0},
      '{-24'sd8388608, -24'sd8388608, 17'd65536, 1'b0, 24'sd0, 24'sd0},
      '{24'sd4194304, -24'sd4194304, 17'd0, 1'b1, 24'sd0, 24'sd0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stereo_console_buss_saturator: mismatch");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_out_left, 'x);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_out_left !== want.left) report_mismatch("out_left", rsp_out_left, want.left);
            if (rsp_out_right !== want.right)
               report_mismatch("out_right", rsp_out_right, want.right);
         end
      end
   end

   // receiver back-pressure
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            stall_left = LONG_HOLD;
            hold_req   = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
         end
      end
   end

   // one write beat, then write enable is dropped before the next write
   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SUB_TRIM) trim_reg = data[15:0];
      else if (idx == CSR_SLEW_THRESHOLD) thr_reg = data[16:0];
      @(negedge clock);
   endtask

   // drive one beat, called at a falling edge, returns at a falling edge
   task automatic send_pair(stim_row_type row, bit allow_gap);
      pair_type want;
      if (allow_gap && !quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_left  <= row.left;
      req_sample_right <= row.right;
      req_fader_gain   <= row.gain;
      do @(posedge clock); while (req_stall);
      want = buss_pair(row.left, row.right, row.gain);
      if (row.known) begin
         want.left  = row.exp_left;
         want.right = row.exp_right;
      end
      pending_pairs.push_back(want);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [SB-1:0] random_sample();
      case ($urandom_range(0, 5))
         0:       return SB'($urandom);
         1:       return $urandom_range(0, 1) ? 24'sd8388607 : -24'sd8388608;
         2:       return SB'(int'($urandom_range(0, 4000)) - 2000);
         default: return SB'(int'($urandom_range(0, 3145728)) - 1572864);
      endcase
   endfunction

   function automatic logic [16:0] random_gain();
      case ($urandom_range(0, 7))
         0:       return 17'($urandom_range(0, 65535));
         1:       return 17'($urandom_range(65537, 131071));
         2:       return 17'($urandom_range(60000, 65535));
         default: return GAIN_UNITY;
      endcase
   endfunction

   initial begin
      stim_row_type row;
      logic [16:0] trims[6];
      logic [16:0] thrs[6];
      build_sine_tab();
      trim_reg = SUB_TRIM_RESET;
      thr_reg  = SLEW_THR_RESET;
      for (int c = 0; c < 2; c++) begin
         slew_mem[c] = 0;
         for (int s = 0; s < 3; s++) sub_mem[c][s] = 0;
      end
      mismatch_count   = 0;
      cycle_count      = 0;
      quiet            = 1'b0;
      hold_req         = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_left  = '0;
      req_sample_right = '0;
      req_fader_gain   = GAIN_UNITY;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_SUB_TRIM;
      csr_wdata        = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) send_pair(dir_rows[i], 1'b1);
      drain();

      // sub trim 17th bit must be dropped; spare indexes ignored
      trims = '{17'h1FFFF, 17'd0, 17'($urandom), 17'd65535, SUB_TRIM_RESET, 17'd40000};
      thrs  = '{17'd131071, 17'd0, 17'($urandom), 17'd1, SLEW_THR_RESET, 17'd8000};
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_SUB_TRIM, trims[ph]);
         csr_write(CSR_SLEW_THRESHOLD, thrs[ph]);
         csr_write(ph[0] ? CSR_SPARE_A : CSR_SPARE_B, 17'($urandom));
         if (ph == 5) quiet = 1'b1;
         for (int n = 0; n < 300; n++) begin
            if (ph == 2 && n == 50) hold_req = 1'b1;
            // let everything drain once mid-phase
            if (ph == 3 && n == 150) drain();
            row.left  = random_sample();
            row.right = random_sample();
            row.gain  = random_gain();
            row.known = 1'b0;
            row.exp_left  = '0;
            row.exp_right = '0;
            send_pair(row, !(ph == 2 && n >= 50 && n < 60));
         end
         drain();
      end

      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("stereo_console_buss_saturator: match");
      end else begin
         $display("stereo_console_buss_saturator: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/scbs_pkg.sv
hw/rtl/scbs_trig_rom.sv
hw/rtl/scbs_datapath.sv
hw/rtl/scbs_ctrl.sv
hw/rtl/stereo_console_buss_saturator.sv
dv/tb_stereo_console_buss_saturator.sv
